>>> src/itpp_pkg.sv
// shared types and constants for the tsmp pong parser
package itpp_pkg;

   localparam int unsigned TOKEN_BYTES_DEF = 8;

   localparam logic [7:0] TSMP_PROTO  = 8'd99;
   localparam logic [7:0] PONG_TYPE   = 8'h6f;
   localparam logic [7:0] FRAG_MASK   = 8'h3f;
   localparam logic [3:0] NIBBLE_MASK = 4'h0f;
   localparam logic [5:0] V6_HDR      = 6'd40;
   localparam logic [5:0] V4_MIN_HDR  = 6'd20;

   localparam logic [3:0] VER_V4 = 4'd4;
   localparam logic [3:0] VER_V6 = 4'd6;

   localparam logic [15:0] POS_FRAG_HI = 16'd6;
   localparam logic [15:0] POS_FRAG_LO = 16'd7;
   localparam logic [15:0] POS_PROTO   = 16'd9;
   localparam logic [15:0] COUNT_MAX   = 16'hffff;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } itpp_req_type;

   typedef struct packed {
      logic        accepted;
      logic [63:0] token_value;
      logic        port_present;
      logic [15:0] peer_port;
   } itpp_rsp_type;

endpackage

>>> src/itpp_parser.sv
// per-packet parse state and verdict logic
module itpp_parser #(
   parameter int unsigned TOKEN_BYTES = itpp_pkg::TOKEN_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  itpp_pkg::itpp_req_type item,
   output itpp_pkg::itpp_rsp_type verdict
);
   import itpp_pkg::*;

   localparam int unsigned TOKEN_W = TOKEN_BYTES * 8;

   logic [15:0]        cnt_ff, cnt_in;
   logic [3:0]         ver_ff, ver_in;
   logic [5:0]         hl_ff, hl_in;
   logic               frag_ff, frag_in;
   logic [7:0]         six_ff, six_in;
   logic [7:0]         nine_ff, nine_in;
   logic [7:0]         msg_ff, msg_in;
   logic [TOKEN_W-1:0] tok_ff, tok_in;
   logic [15:0]        port_ff, port_in;

   logic [7:0]         b;
   logic               at_zero;
   logic [3:0]         ver_now;
   logic [5:0]         hl_now;
   logic               frag_now;
   logic [7:0]         six_now, nine_now, msg_now;
   logic [TOKEN_W-1:0] tok_now;
   logic [15:0]        port_now;
   logic [5:0]         off;
   logic [16:0]        pos17, off17, tb17, tok_end, len17;
   logic               ok, acc, port_ok;

   always_comb begin
      b        = item.data_byte;
      at_zero  = (cnt_ff == '0);
      ver_now  = at_zero ? b[7:4] : ver_ff;
      hl_now   = at_zero ? {b[3:0] & NIBBLE_MASK, 2'b00} : hl_ff;
      frag_now = frag_ff
               | ((cnt_ff == POS_FRAG_HI) && ((b & FRAG_MASK) != '0))
               | ((cnt_ff == POS_FRAG_LO) && (b != '0));
      six_now  = (cnt_ff == POS_FRAG_HI) ? b : six_ff;
      nine_now = (cnt_ff == POS_PROTO) ? b : nine_ff;

      // payload offset uses the version as seen after this byte
      off     = (ver_now == VER_V4) ? hl_now : V6_HDR;
      pos17   = {1'b0, cnt_ff};
      off17   = 17'(off);
      tb17    = 17'(TOKEN_BYTES);
      tok_end = off17 + tb17;

      msg_now  = (pos17 == off17) ? b : msg_ff;
      tok_now  = ((pos17 > off17) && (pos17 <= tok_end))
               ? TOKEN_W'({tok_ff, b}) : tok_ff;
      port_now = ((pos17 > tok_end) && (pos17 <= tok_end + 17'd2))
               ? {port_ff[7:0], b} : port_ff;

      len17 = (cnt_ff == COUNT_MAX) ? 17'(COUNT_MAX) : pos17 + 17'd1;

      ok = 1'b0;
      case (ver_now)
         VER_V4: ok = (len17 >= 17'(V4_MIN_HDR)) && (nine_now == TSMP_PROTO) && !frag_now
                      && (hl_now >= V4_MIN_HDR) && (17'(hl_now) <= len17);
         VER_V6: ok = (len17 >= 17'(V6_HDR)) && (six_now == TSMP_PROTO);
         default: ok = 1'b0;
      endcase

      acc     = ok && (len17 >= tok_end + 17'd1) && (msg_now == PONG_TYPE);
      port_ok = acc && (len17 >= tok_end + 17'd3);

      verdict.accepted     = acc;
      verdict.token_value  = acc ? 64'(tok_now) : '0;
      verdict.port_present = port_ok;
      verdict.peer_port    = port_ok ? port_now : '0;
   end

   always_comb begin
      cnt_in  = cnt_ff;
      ver_in  = ver_ff;
      hl_in   = hl_ff;
      frag_in = frag_ff;
      six_in  = six_ff;
      nine_in = nine_ff;
      msg_in  = msg_ff;
      tok_in  = tok_ff;
      port_in = port_ff;
      if (fire) begin
         if (item.last_byte) begin
            cnt_in  = '0;
            ver_in  = '0;
            hl_in   = '0;
            frag_in = 1'b0;
            six_in  = '0;
            nine_in = '0;
            msg_in  = '0;
            tok_in  = '0;
            port_in = '0;
         end else begin
            cnt_in  = (cnt_ff == COUNT_MAX) ? cnt_ff : cnt_ff + 16'd1;
            ver_in  = ver_now;
            hl_in   = hl_now;
            frag_in = frag_now;
            six_in  = six_now;
            nine_in = nine_now;
            msg_in  = msg_now;
            tok_in  = tok_now;
            port_in = port_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         ver_ff  <= '0;
         hl_ff   <= '0;
         frag_ff <= 1'b0;
         six_ff  <= '0;
         nine_ff <= '0;
         msg_ff  <= '0;
         tok_ff  <= '0;
         port_ff <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         ver_ff  <= ver_in;
         hl_ff   <= hl_in;
         frag_ff <= frag_in;
         six_ff  <= six_in;
         nine_ff <= nine_in;
         msg_ff  <= msg_in;
         tok_ff  <= tok_in;
         port_ff <= port_in;
      end
   end

`ifndef SYNTH
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      fire && item.last_byte |=> cnt_ff == '0 && tok_ff == '0 && port_ff == '0)
      else $error("parse state not cleared after last byte");

   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      fire && !item.last_byte && cnt_ff != COUNT_MAX |=> cnt_ff == $past(cnt_ff) + 16'd1)
      else $error("byte count did not advance");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(cnt_ff) && $stable(tok_ff))
      else $error("parse state moved without an item");
`endif

endmodule

>>> src/ip_tsmp_pong_parser_top.sv
// top level of the tsmp pong parser: input register, parser, result register
// path: a final byte's verdict is computed as it leaves the input register and is held in
//    the result register; the byte waits in the input register while a result is held unread
// throughput: one byte per cycle except during that wait, set by the input and result registers
// non-final bytes give no result and never wait on the result side
// reset: synchronous active-high, empties both registers and clears parse state
// no clearing pass: the block is ready right after reset
module ip_tsmp_pong_parser_top #(
   parameter int unsigned TOKEN_BYTES = itpp_pkg::TOKEN_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  itpp_pkg::itpp_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output itpp_pkg::itpp_rsp_type rsp_data
);
   import itpp_pkg::*;

   // input register
   logic         s1_valid_ff, s1_valid_in;
   itpp_req_type s1_ff;
   logic         s1_fire;

   // result register
   logic         rsp_valid_ff, rsp_valid_in;
   itpp_rsp_type rsp_ff;

   itpp_rsp_type verdict;

   // a non-final byte leaves no result, so it can always move on;
   // a final byte needs the result slot free or draining this cycle
   assign s1_fire = s1_valid_ff
                  && (!s1_ff.last_byte || !rsp_valid_ff || rsp_ready);

   // input register takes a new item when empty or when its item moves on
   assign req_ready = !s1_valid_ff || s1_fire;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_fire && s1_ff.last_byte) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_ff <= req_data;
      end
      if (s1_fire && s1_ff.last_byte) begin
         rsp_ff <= verdict;
      end
   end

   // header and payload tracking, verdict on the final byte
   itpp_parser #(
      .TOKEN_BYTES(TOKEN_BYTES)
   ) u_parser (
      .clock  (clock),
      .reset  (reset),
      .fire   (s1_fire),
      .item   (s1_ff),
      .verdict(verdict)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_ff.last_byte && rsp_valid_ff && !rsp_ready |-> !s1_fire)
      else $error("final item would overwrite a pending result");

   a_reject_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.accepted |->
         rsp_data.token_value == '0 && !rsp_data.port_present)
      else $error("rejected item carries token or port");

   a_port_needs_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.port_present |-> rsp_data.peer_port == '0)
      else $error("peer port set without port present");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("waiting result changed or dropped");
`endif

endmodule

>>> sim/ip_tsmp_pong_parser_top_tb.sv
// self-checking testbench for the tsmp pong parser: directed packet table, then random packets
module ip_tsmp_pong_parser_top_tb;
   import itpp_pkg::*;

   localparam int unsigned TOKEN_N = TOKEN_BYTES_DEF;

   // verdict of a packet that is not a pong
   localparam itpp_rsp_type REJECT = '0;
   localparam logic [63:0] TOK_A = 64'h0123_4567_89ab_cdef;
   localparam logic [63:0] TOK_ONES = '1;

   // one packet to send: key header bytes, payload content and total length
   typedef struct packed {
      logic [7:0]   b0;
      logic [7:0]   b6;
      logic [7:0]   b7;
      logic [7:0]   b9;
      logic [7:0]   mtype;
      bit [16:0]    len;
      logic [63:0]  tok;
      logic [15:0]  port;
      bit           typed;
      itpp_rsp_type want;
   } pkt_row_type;

   // one byte on its way to the block, with a typed verdict on the final byte
   typedef struct packed {
      itpp_req_type req;
      bit           typed;
      itpp_rsp_type want;
   } byte_item_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   itpp_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   itpp_rsp_type rsp_data;

   ip_tsmp_pong_parser_top #(
      .TOKEN_BYTES(TOKEN_N)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // bytes not yet accepted, front one is on the bus
   byte_item_type byte_q[$];
   // verdicts still owed by the block
   itpp_rsp_type  verdict_q[$];

   int unsigned snd_idle = 0;
   int unsigned rcv_idle = 0;
   bit          req_fire = 1'b0;
   int unsigned errors = 0;
   int unsigned verdicts_checked = 0;
   int unsigned sent_pkts = 0;
   int unsigned sent_bytes = 0;

   // parser shadow state, cleared after every final byte
   logic [15:0] pr_count = '0;
   logic [3:0]  pr_ver = '0;
   logic [5:0]  pr_hlen = '0;
   logic        pr_frag = 1'b0;
   logic [7:0]  pr_b6 = '0;
   logic [7:0]  pr_b9 = '0;
   logic [7:0]  pr_type = '0;
   logic [63:0] pr_token = '0;
   logic [15:0] pr_port = '0;

   // directed packets: lengths assume an 8-byte token (v4 ihl 5 pong with port is 31 bytes)
   pkt_row_type dir_rows [24] = '{
      // minimal ipv4 pong, no port
      '{8'h45, 8'h00, 8'h00, TSMP_PROTO, PONG_TYPE, 17'd29, TOK_A, 16'h0000, 1'b1,
        '{1'b1, TOK_A, 1'b0, 16'h0000}},
      // ipv4 pong with port
      '{8'h45, 8'h00, 8'h00, TSMP_PROTO, PONG_TYPE, 17'd31, TOK_A, 16'hbeef, 1'b1,
        '{1'b1, TOK_A, 1'b1, 16'hbeef}},
      // all-ones token and port
      '{8'h45, 8'h00, 8'h00, TSMP_PROTO, PONG_TYPE, 17'd31, TOK_ONES, 16'hffff, 1'b1,
        '{1'b1, TOK_ONES, 1'b1, 16'hffff}},
      // all-zero token and port
      '{8'h45, 8'h00, 8'h00, TSMP_PROTO, PONG_TYPE, 17'd31, 64'h0, 16'h0000, 1'b1,
        '{1'b1, 64'h0, 1'b1, 16'h0000}},
      // only one port byte present
      '{8'h45, 8'h00, 8'h00, TSMP_PROTO, PONG_TYPE, 17'd30, TOK_A, 16'hbeef, 1'b0, REJECT},
      // flag bits in byte 6 are outside the fragment mask
      '{8'h45, 8'hc0, 8'h00, TSMP_PROTO, PONG_TYPE, 17'd31, TOK_A, 16'h1234, 1'b0, REJECT},
      // fragment offset bit in byte 6
      '{8'h45, 8'h01, 8'h00, TSMP_PROTO, PONG_TYPE, 17'd31, TOK_A, 16'h1234, 1'b1, REJECT},
      // fragment offset bit in byte 7
      '{8'h45, 8'h00, 8'h80, TSMP_PROTO, PONG_TYPE, 17'd31, TOK_A, 16'h1234, 1'b1, REJECT},
      // wrong protocol
      '{8'h45, 8'h00, 8'h00, 8'd98, PONG_TYPE, 17'd31, TOK_A, 16'h1234, 1'b1, REJECT},
      // ipv4 with the protocol in byte 6 only: no ipv6 fall-back
      '{8'h45, TSMP_PROTO, 8'h00, 8'h00, PONG_TYPE, 17'd31, TOK_A, 16'h1234, 1'b1, REJECT},
      // wrong message type
      '{8'h45, 8'h00, 8'h00, TSMP_PROTO, 8'h69, 17'd31, TOK_A, 16'h1234, 1'b1, REJECT},
      // token cut short
      '{8'h45, 8'h00, 8'h00, TSMP_PROTO, PONG_TYPE, 17'd28, TOK_A, 16'h1234, 1'b1, REJECT},
      // header only
      '{8'h45, 8'h00, 8'h00, TSMP_PROTO, PONG_TYPE, 17'd20, TOK_A, 16'h1234, 1'b1, REJECT},
      // ihl below the minimum
      '{8'h44, 8'h00, 8'h00, TSMP_PROTO, PONG_TYPE, 17'd31, TOK_A, 16'h1234, 1'b0, REJECT},
      // largest ihl, payload at 60
      '{8'h4f, 8'h00, 8'h00, TSMP_PROTO, PONG_TYPE, 17'd71, TOK_A, 16'h4321, 1'b0, REJECT},
      // ihl reaches past the packet end
      '{8'h4f, 8'h00, 8'h00, TSMP_PROTO, PONG_TYPE, 17'd40, TOK_A, 16'h4321, 1'b1, REJECT},
      // one-byte packets
      '{8'h45, 8'h00, 8'h00, TSMP_PROTO, PONG_TYPE, 17'd1, TOK_A, 16'h0000, 1'b1, REJECT},
      '{8'h00, 8'h00, 8'h00, TSMP_PROTO, PONG_TYPE, 17'd1, TOK_A, 16'h0000, 1'b1, REJECT},
      // ipv6 pong, byte 7 does not matter
      '{8'h60, TSMP_PROTO, 8'hff, 8'h00, PONG_TYPE, 17'd51, TOK_A, 16'h1234, 1'b0, REJECT},
      // ipv6 pong without port
      '{8'h6a, TSMP_PROTO, 8'h00, 8'hff, PONG_TYPE, 17'd49, TOK_ONES, 16'h0000, 1'b1,
        '{1'b1, TOK_ONES, 1'b0, 16'h0000}},
      // ipv6 token cut short
      '{8'h60, TSMP_PROTO, 8'h00, 8'h00, PONG_TYPE, 17'd48, TOK_A, 16'h1234, 1'b1, REJECT},
      // ipv6 wrong next header
      '{8'h60, 8'd98, 8'h00, TSMP_PROTO, PONG_TYPE, 17'd51, TOK_A, 16'h1234, 1'b1, REJECT},
      // other versions
      '{8'h55, 8'h00, 8'h00, TSMP_PROTO, PONG_TYPE, 17'd51, TOK_A, 16'h1234, 1'b1, REJECT},
      '{8'hff, TSMP_PROTO, 8'h00, TSMP_PROTO, PONG_TYPE, 17'd51, TOK_A, 16'h1234, 1'b1, REJECT}
   };

   // shadow parser: takes one byte, returns 1 with the verdict on a final byte
   function automatic bit parse_byte(input itpp_req_type it, output itpp_rsp_type verdict);
      logic [7:0]  b;
      int unsigned pos;
      int unsigned off;
      int unsigned len;
      bit          ok;
      b = it.data_byte;
      pos = pr_count;
      verdict = '0;
      if (pos == 0) begin
         pr_ver = b[7:4];
         pr_hlen = {b[3:0], 2'b00};
      end
      if (pos == POS_FRAG_HI) begin
         pr_b6 = b;
         if ((b & FRAG_MASK) != 0) pr_frag = 1'b1;
      end
      if (pos == POS_FRAG_LO && b != 0) pr_frag = 1'b1;
      if (pos == POS_PROTO) pr_b9 = b;
      // payload offset follows the version seen so far
      off = (pr_ver == VER_V4) ? pr_hlen : V6_HDR;
      if (pos == off) pr_type = b;
      if (pos > off && pos <= off + TOKEN_N) pr_token = {pr_token[55:0], b};
      if (pos > off + TOKEN_N && pos <= off + TOKEN_N + 2) pr_port = {pr_port[7:0], b};
      if (!it.last_byte) begin
         if (pr_count != COUNT_MAX) pr_count = pr_count + 1'b1;
         return 1'b0;
      end
      len = pos + 1;
      if (len > COUNT_MAX) len = COUNT_MAX;
      ok = 1'b0;
      if (pr_ver == VER_V4) begin
         ok = len >= V4_MIN_HDR && pr_b9 == TSMP_PROTO && !pr_frag &&
              pr_hlen >= V4_MIN_HDR && pr_hlen <= len;
      end else if (pr_ver == VER_V6) begin
         ok = len >= V6_HDR && pr_b6 == TSMP_PROTO;
      end
      if (ok && len >= off + 1 + TOKEN_N && pr_type == PONG_TYPE) begin
         verdict.accepted = 1'b1;
         verdict.token_value = pr_token;
         if (len >= off + 3 + TOKEN_N) begin
            verdict.port_present = 1'b1;
            verdict.peer_port = pr_port;
         end
      end
      pr_count = '0;
      pr_ver = '0;
      pr_hlen = '0;
      pr_frag = 1'b0;
      pr_b6 = '0;
      pr_b9 = '0;
      pr_type = '0;
      pr_token = '0;
      pr_port = '0;
      return 1'b1;
   endfunction

   // turn a packet row into bytes; header bytes win where the payload overlaps them
   task automatic queue_packet(input pkt_row_type r);
      int unsigned   off;
      logic [7:0]    b;
      byte_item_type it;
      off = (r.b0[7:4] == VER_V4) ? r.b0[3:0] * 4 : V6_HDR;
      for (int unsigned i = 0; i < r.len; i++) begin
         b = 8'($urandom);
         if (i == off) b = r.mtype;
         if (i > off && i <= off + TOKEN_N) b = r.tok[8 * (off + TOKEN_N - i) +: 8];
         if (i == off + TOKEN_N + 1) b = r.port[15:8];
         if (i == off + TOKEN_N + 2) b = r.port[7:0];
         if (i == 0) b = r.b0;
         if (i == POS_FRAG_HI) b = r.b6;
         if (i == POS_FRAG_LO) b = r.b7;
         if (i == POS_PROTO) b = r.b9;
         it.req.data_byte = b;
         it.req.last_byte = (i == r.len - 1);
         it.typed = r.typed && it.req.last_byte;
         it.want = r.want;
         byte_q.push_back(it);
      end
      sent_pkts++;
      sent_bytes += r.len;
   endtask

   // mostly well-formed pongs with random content, some broken, some plain noise
   task automatic queue_random_packet(output int unsigned len);
      pkt_row_type r;
      int unsigned kind;
      int unsigned ihl;
      int unsigned full;
      kind = $urandom_range(9);
      r.tok = {$urandom, $urandom};
      r.port = 16'($urandom);
      r.typed = 1'b0;
      r.want = REJECT;
      if (kind <= 5) begin
         ihl = ($urandom_range(3) == 0) ? $urandom_range(15, 5) : 5;
         r.b0 = {VER_V4, ihl[3:0]};
         r.b6 = {2'($urandom_range(3)), 6'b0};
         r.b7 = 8'h00;
         r.b9 = TSMP_PROTO;
         r.mtype = PONG_TYPE;
         full = ihl * 4 + TOKEN_N + 3;
      end else if (kind <= 7) begin
         r.b0 = {VER_V6, 4'($urandom)};
         r.b6 = TSMP_PROTO;
         r.b7 = 8'($urandom);
         r.b9 = 8'($urandom);
         r.mtype = PONG_TYPE;
         full = V6_HDR + TOKEN_N + 3;
      end else begin
         r.b0 = 8'($urandom);
         r.b6 = 8'($urandom);
         r.b7 = 8'($urandom);
         r.b9 = 8'($urandom);
         r.mtype = 8'($urandom);
         full = 40;
      end
      if (kind <= 7) begin
         // break one field now and then
         if ($urandom_range(3) == 0) begin
            case ($urandom_range(5))
               0: r.b0[7:4] = 4'($urandom);
               1: r.b6 = 8'($urandom);
               2: r.b7 = 8'($urandom);
               3: r.b9 = 8'($urandom);
               4: r.mtype = 8'($urandom);
               default: r.b0[3:0] = 4'($urandom);
            endcase
         end
         if ($urandom_range(3) == 0) len = $urandom_range(full, 1);
         else len = full - $urandom_range(2) + $urandom_range(3);
      end else begin
         len = $urandom_range(full, 1);
      end
      r.len = 17'(len);
      queue_packet(r);
   endtask

   // sample both handshakes at the rising edge, before the block updates
   always @(posedge clock) begin
      byte_item_type it;
      itpp_rsp_type  got_v;
      req_fire = 1'b0;
      if (!reset) begin
         req_fire = req_valid && req_ready;
         if (req_fire) begin
            it = byte_q.pop_front();
            // table rows with a typed verdict override the shadow parser
            if (parse_byte(it.req, got_v)) verdict_q.push_back(it.typed ? it.want : got_v);
         end
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               $error("verdict with none expected: %p", rsp_data);
               errors++;
            end else begin
               got_v = verdict_q.pop_front();
               if (rsp_data.accepted !== got_v.accepted) begin
                  $error("accepted: expected %0d, got %0d", got_v.accepted, rsp_data.accepted);
                  errors++;
               end
               if (rsp_data.token_value !== got_v.token_value) begin
                  $error("token_value: expected %h, got %h",
                         got_v.token_value, rsp_data.token_value);
                  errors++;
               end
               if (rsp_data.port_present !== got_v.port_present) begin
                  $error("port_present: expected %0d, got %0d",
                         got_v.port_present, rsp_data.port_present);
                  errors++;
               end
               if (rsp_data.peer_port !== got_v.peer_port) begin
                  $error("peer_port: expected %h, got %h", got_v.peer_port, rsp_data.peer_port);
                  errors++;
               end
            end
            verdicts_checked++;
         end
      end
   end

   // drive on the falling edge: hold an item until taken, else maybe idle
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rcv_idle);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         req_valid <= 1'b1;
      end else if (byte_q.size() != 0 && $urandom_range(99) >= snd_idle) begin
         req_valid <= 1'b1;
         req_data <= byte_q[0].req;
      end else begin
         req_valid <= 1'b0;
      end
   end

   initial begin
      int unsigned phase_bytes;
      int unsigned phase_pkts;
      int unsigned len;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 3; ph++) begin
         // receiver-heavy idling, then sender-heavy, then none
         case (ph)
            0: begin
               snd_idle = 18;
               rcv_idle = 55;
            end
            1: begin
               snd_idle = 55;
               rcv_idle = 18;
            end
            default: begin
               snd_idle = 0;
               rcv_idle = 0;
            end
         endcase
         if (ph == 0) begin
            foreach (dir_rows[i]) queue_packet(dir_rows[i]);
         end
         phase_bytes = 0;
         phase_pkts = 0;
         while (phase_bytes < 40 || phase_pkts < 2) begin
            queue_random_packet(len);
            phase_bytes += len;
            phase_pkts++;
         end
         while (byte_q.size() != 0) @(posedge clock);
      end
      // drain the verdicts still in flight, then watch for strays
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d packets, %0d bytes, three idling phases", sent_pkts, sent_bytes);
      $display("checked %0d verdicts, %0d mismatches", verdicts_checked, errors);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // hang guard, far beyond the slowest correct run
   initial begin
      #(12 * 600000);
      $display("FAILURE");
      $finish;
   end

endmodule
